### design/tts_pkg.sv
package tts_pkg;

  // command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_DELETE   = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_e;

  // result kinds carried on the output tuser
  typedef enum logic [2:0] {
    KIND_DONE  = 3'd0,
    KIND_ADDED = 3'd1,
    KIND_FULL  = 3'd2,
    KIND_RUN   = 3'd3,
    KIND_NONE  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned DELAY_W   = 16;
  localparam int unsigned PENDING_W = 8;
  localparam int unsigned SLOT_W    = 3;

  // cap on run results per dispatch
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned SERVED_W    = 4;

  localparam logic [PENDING_W-1:0] PENDING_MAX = '1;

  typedef struct packed {
    logic                 valid;
    logic [HANDLE_W-1:0]  handle;
    logic [DELAY_W-1:0]   delay;
    logic [DELAY_W-1:0]   period;
    logic [PENDING_W-1:0] pending;
  } slot_rec_t;

  // per-slot context handed from the control to the slot update unit
  typedef struct packed {
    cmd_e                cmd;
    logic                found;      // add: a free slot was already taken
    logic                idx_hit;    // delete: head is the addressed slot
    logic                served_full;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  delay;
    logic [DELAY_W-1:0]  period;
  } slot_ctx_t;

endpackage

### design/tts_cell.sv
// One table entry in the rotating ring.
module tts_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               shift_i,
  input  tts_pkg::slot_rec_t d_i,
  output tts_pkg::slot_rec_t q_o
);

  tts_pkg::slot_rec_t rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else if (shift_i) begin
      rec_q <= d_i;
    end
  end

  assign q_o = rec_q;

endmodule

### design/tts_slot_unit.sv
// Applies the current command to the record at the head of the ring.
module tts_slot_unit (
  input  tts_pkg::slot_ctx_t ctx_i,
  input  tts_pkg::slot_rec_t rec_i,
  output tts_pkg::slot_rec_t rec_o,
  output logic               hit_o
);

  always_comb begin
    rec_o = rec_i;
    hit_o = 1'b0;
    unique case (ctx_i.cmd)
      tts_pkg::CMD_TICK: begin
        if (rec_i.valid) begin
          if (rec_i.delay == '0) begin
            if (rec_i.pending != tts_pkg::PENDING_MAX) begin
              rec_o.pending = rec_i.pending + 1'b1;
            end
            if (rec_i.period != '0) begin
              rec_o.delay = rec_i.period;
            end
          end else begin
            rec_o.delay = rec_i.delay - 1'b1;
          end
        end
      end
      tts_pkg::CMD_ADD: begin
        if (!rec_i.valid && !ctx_i.found) begin
          hit_o         = 1'b1;
          rec_o.valid   = 1'b1;
          rec_o.handle  = ctx_i.handle;
          rec_o.delay   = ctx_i.delay;
          rec_o.period  = ctx_i.period;
          rec_o.pending = '0;
        end
      end
      tts_pkg::CMD_DELETE: begin
        if (ctx_i.idx_hit) begin
          rec_o = '0;
        end
      end
      tts_pkg::CMD_DISPATCH: begin
        if (rec_i.pending != '0 && !ctx_i.served_full) begin
          hit_o         = 1'b1;
          rec_o.pending = rec_i.pending - 1'b1;
          if (rec_i.period == '0) begin
            rec_o = '0;
          end
        end
      end
      default: begin
        rec_o = rec_i;
      end
    endcase
  end

endmodule

### design/tick_task_scheduler_table.sv
// Time-triggered task table. The slots sit in a ring of cells that rotates
// one position per cycle while a command is worked; the head slot passes
// through a shared update unit and re-enters at the tail, so after
// MAX_TASKS steps the table is back in index order. Every command (tick,
// add, delete, dispatch) walks the ring once and then presents its final
// result from the finish state; the input is ready again only once the
// control is back in idle, so a new command is not taken before the last
// one is through. The walk pauses whenever a dispatch run result cannot
// leave because the output holds a transaction not yet taken, and the final
// result of any command waits the same way. Dispatch results are held one
// slot behind the walk so the final one can be flagged with tlast.
module tick_task_scheduler_table_core #(
  parameter int unsigned MAX_TASKS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [31:0] task_handle, [47:32] start_delay, [63:48] repeat_period,
  // [66:64] slot_index, [71:67] zero
  input  logic [71:0] s_axis_tdata_i,
  // [1:0] command
  input  logic [1:0]  s_axis_tuser_i,
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] slot, [34:3] handle_out, [39:35] zero
  output logic [39:0] m_axis_tdata_o,
  // [2:0] result_kind
  output logic [2:0]  m_axis_tuser_o,
  // last
  output logic        m_axis_tlast_o
);

  localparam int unsigned CW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(MAX_TASKS - 1);

  tts_pkg::state_e state_q, state_d;

  // latched command of the transaction in progress
  tts_pkg::cmd_e                 cmd_q;
  logic [tts_pkg::HANDLE_W-1:0]  handle_q;
  logic [tts_pkg::DELAY_W-1:0]   delay_q;
  logic [tts_pkg::DELAY_W-1:0]   period_q;
  logic [tts_pkg::SLOT_W-1:0]    idx_q;

  logic [CW-1:0]                 cnt_q;
  logic                          found_q;
  logic [tts_pkg::SLOT_W-1:0]    found_slot_q;
  logic [tts_pkg::SERVED_W-1:0]  served_q;

  // one dispatch result held back until the next one (or the end) is known
  logic                          hold_valid_q;
  logic [tts_pkg::SLOT_W-1:0]    hold_slot_q;
  logic [tts_pkg::HANDLE_W-1:0]  hold_handle_q;

  // output register
  logic                          out_valid_q;
  tts_pkg::kind_e                out_kind_q;
  logic [tts_pkg::SLOT_W-1:0]    out_slot_q;
  logic [tts_pkg::HANDLE_W-1:0]  out_handle_q;
  logic                          out_last_q;

  logic                          accept;
  logic                          out_free;
  logic                          step;
  logic                          load_out;
  tts_pkg::kind_e                new_kind;
  logic [tts_pkg::SLOT_W-1:0]    new_slot;
  logic [tts_pkg::HANDLE_W-1:0]  new_handle;
  logic                          new_last;

  logic [31:0]                   cnt_ext;
  logic [tts_pkg::SLOT_W-1:0]    cnt_slot;

  tts_pkg::slot_rec_t            ring_q [MAX_TASKS];
  tts_pkg::slot_rec_t            ring_d [MAX_TASKS];
  tts_pkg::slot_rec_t            head_new;
  tts_pkg::slot_ctx_t            ctx;
  logic                          hit;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign cnt_ext  = 32'(cnt_q);
  assign cnt_slot = cnt_ext[tts_pkg::SLOT_W-1:0];

  // ring of slot cells: each takes its upper neighbor, the tail takes the
  // updated head
  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_ring
    if (g == MAX_TASKS - 1) begin : g_tail
      assign ring_d[g] = head_new;
    end else begin : g_body
      assign ring_d[g] = ring_q[g+1];
    end
    tts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(step),
      .d_i    (ring_d[g]),
      .q_o    (ring_q[g])
    );
  end

  always_comb begin
    ctx.cmd         = cmd_q;
    ctx.found       = found_q;
    ctx.idx_hit     = (cnt_ext == 32'(idx_q));
    ctx.served_full = (served_q == tts_pkg::SERVED_W'(tts_pkg::MAX_RESULTS));
    ctx.handle      = handle_q;
    ctx.delay       = delay_q;
    ctx.period      = period_q;
  end

  tts_slot_unit u_slot (
    .ctx_i(ctx),
    .rec_i(ring_q[0]),
    .rec_o(head_new),
    .hit_o(hit)
  );

  // control: walk stepping and result selection
  always_comb begin
    state_d    = state_q;
    step       = 1'b0;
    load_out   = 1'b0;
    new_kind   = tts_pkg::KIND_DONE;
    new_slot   = '0;
    new_handle = '0;
    new_last   = 1'b0;
    s_axis_tready_o = (state_q == tts_pkg::ST_IDLE);
    unique case (state_q)
      tts_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = tts_pkg::ST_WALK;
        end
      end
      tts_pkg::ST_WALK: begin
        if (cmd_q == tts_pkg::CMD_DISPATCH && hit && hold_valid_q) begin
          // a further ready slot: the held one is not the last
          step       = out_free;
          load_out   = out_free;
          new_kind   = tts_pkg::KIND_RUN;
          new_slot   = hold_slot_q;
          new_handle = hold_handle_q;
        end else begin
          step = 1'b1;
        end
        if (step && cnt_q == LAST_CNT) begin
          state_d = tts_pkg::ST_FINISH;
        end
      end
      tts_pkg::ST_FINISH: begin
        new_last = 1'b1;
        unique case (cmd_q)
          tts_pkg::CMD_ADD: begin
            if (found_q) begin
              new_kind = tts_pkg::KIND_ADDED;
              new_slot = found_slot_q;
            end else begin
              new_kind = tts_pkg::KIND_FULL;
            end
          end
          tts_pkg::CMD_DISPATCH: begin
            if (hold_valid_q) begin
              new_kind   = tts_pkg::KIND_RUN;
              new_slot   = hold_slot_q;
              new_handle = hold_handle_q;
            end else begin
              new_kind = tts_pkg::KIND_NONE;
            end
          end
          default: begin
            new_kind = tts_pkg::KIND_DONE;
          end
        endcase
        if (out_free) begin
          load_out = 1'b1;
          state_d  = tts_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tts_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tts_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // walk bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      found_q      <= 1'b0;
      served_q     <= '0;
      hold_valid_q <= 1'b0;
      cmd_q        <= tts_pkg::CMD_TICK;
    end else if (accept) begin
      cnt_q        <= '0;
      found_q      <= 1'b0;
      served_q     <= '0;
      hold_valid_q <= 1'b0;
      cmd_q        <= tts_pkg::cmd_e'(s_axis_tuser_i);
    end else if (step) begin
      cnt_q <= cnt_q + 1'b1;
      if (hit && cmd_q == tts_pkg::CMD_ADD) begin
        found_q <= 1'b1;
      end
      if (hit && cmd_q == tts_pkg::CMD_DISPATCH) begin
        hold_valid_q <= 1'b1;
        served_q     <= served_q + 1'b1;
      end
    end
  end

  // payload of the command and held results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      handle_q <= s_axis_tdata_i[31:0];
      delay_q  <= s_axis_tdata_i[47:32];
      period_q <= s_axis_tdata_i[63:48];
      idx_q    <= s_axis_tdata_i[66:64];
    end
    if (step && hit) begin
      found_slot_q  <= cnt_slot;
      hold_slot_q   <= cnt_slot;
      hold_handle_q <= ring_q[0].handle;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_kind_q   <= new_kind;
      out_slot_q   <= new_slot;
      out_handle_q <= new_handle;
      out_last_q   <= new_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_handle_q, out_slot_q};
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule
